// ===== hw/rtl/fsat_pkg.sv =====
package fsat_pkg;

  // result status codes
  typedef enum logic [1:0] {
    ST_UPDATED = 2'd0,
    ST_CREATED = 2'd1,
    ST_SKIPPED = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  localparam logic [63:0] EPOCH_NONE = 64'hFFFF_FFFF_FFFF_FFFF;

  // input item: 257 bits, 256 on tdata and the create flag on tuser
  typedef struct packed {
    logic        create_if_absent;
    logic [31:0] total_byte_delta;
    logic [31:0] live_byte_delta;
    logic [31:0] total_key_delta;
    logic [31:0] live_key_delta;
    logic [63:0] expiry_epoch;
    logic [31:0] tstamp;
    logic [31:0] file_id;
  } item_t;

  // result item: 390 bits, padded to 392 on the bus
  typedef struct packed {
    logic [31:0] newest_stamp;
    logic [31:0] oldest_stamp;
    logic [63:0] earliest_expiry;
    logic [63:0] tbyte_cnt;
    logic [63:0] lbyte_cnt;
    logic [63:0] tkey_cnt;
    logic [63:0] lkey_cnt;
    logic [3:0]  slot;
    status_e     status;
  } result_t;

endpackage

// ===== hw/rtl/file_stats_accumulator_table_core.sv =====
// channel  | dir | tdata                                            | tuser
// s_axis   | in  | file_id,tstamp,expiry_epoch,4 deltas (256 bits)  | create_if_absent
// m_axis   | out | status,slot,4 counters,expiry,oldest,newest      | -
// one item per cycle while the output is not stalled: a two-entry queue
// feeds the lookup/update stage, which searches all slots in parallel and
// writes the entry in the same cycle; each item passes through the queue,
// then the result register. reset clears the valid bits at once.
// either side may stall without losing or repeating transfers.
module file_stats_accumulator_table_core #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // file_id, tstamp, expiry_epoch, live_key_delta, total_key_delta,
  // live_byte_delta, total_byte_delta
  input  logic [255:0] s_axis_tdata,
  // create_if_absent
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status, slot, live key count, total key count, live byte count,
  // total byte count, earliest_expiry, oldest_stamp, newest_stamp, zero pad
  output logic [391:0] m_axis_tdata
);
  import fsat_pkg::*;

  item_t   in_item, q_item;
  result_t res;
  logic    q_valid, q_ready;

  assign in_item = {s_axis_tuser, s_axis_tdata};
  assign m_axis_tdata = {2'b00, res};

  fsat_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready), .in_item_i(in_item),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_item_o(q_item)
  );

  fsat_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_item_i(q_item),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .out_res_o(res)
  );
endmodule

// ===== hw/rtl/fsat_front.sv =====
// two-entry queue of accepted items
module fsat_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  fsat_pkg::item_t      in_item_i,
  output logic                 q_valid_o,
  input  logic                 q_ready_i,
  output fsat_pkg::item_t      q_item_o
);
  import fsat_pkg::*;

  // two-entry queue
  item_t      mem_q [2];
  logic       wr_q, rd_q, wr_d, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign in_ready_o = (cnt_q != 2'd2);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = mem_q[rd_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = q_valid_o && q_ready_i;

  always_comb begin
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= in_item_i;
    end
  end
endmodule

// ===== hw/rtl/fsat_back.sv =====
// table lookup, update and result register
module fsat_back #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  output logic                 q_ready_o,
  input  fsat_pkg::item_t      q_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output fsat_pkg::result_t    out_res_o
);
  import fsat_pkg::*;

  localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  logic [TABLE_ENTRIES-1:0] vld_q;
  logic [31:0] id_q     [TABLE_ENTRIES];
  logic [63:0] lk_q     [TABLE_ENTRIES];
  logic [63:0] tk_q     [TABLE_ENTRIES];
  logic [63:0] lb_q     [TABLE_ENTRIES];
  logic [63:0] tb_q     [TABLE_ENTRIES];
  logic [63:0] exp_q    [TABLE_ENTRIES];
  logic [31:0] old_q    [TABLE_ENTRIES];
  logic [31:0] new_q    [TABLE_ENTRIES];

  logic        out_valid_q;
  result_t     res_q, res_d;
  logic        hit, fre, take, wr;
  logic [IW-1:0] hidx, fidx, s;
  logic [63:0] lk, tk, lb, tb, ex;
  logic [31:0] od, nw;

  assign q_ready_o   = !out_valid_q || out_ready_i;
  assign take        = q_valid_i && q_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

  // parallel id match and lowest free slot
  always_comb begin
    hit  = 1'b0;
    fre  = 1'b0;
    hidx = '0;
    fidx = '0;
    for (int k = TABLE_ENTRIES - 1; k >= 0; k--) begin
      if (vld_q[k] && id_q[k] == q_item_i.file_id) begin
        hit  = 1'b1;
        hidx = IW'(k);
      end
      if (!vld_q[k]) begin
        fre  = 1'b1;
        fidx = IW'(k);
      end
    end
  end

  // merge into the selected record
  always_comb begin
    s  = hit ? hidx : fidx;
    wr = take && (hit || (q_item_i.create_if_absent && fre));
    lk = hit ? lk_q[s] : '0;
    tk = hit ? tk_q[s] : '0;
    lb = hit ? lb_q[s] : '0;
    tb = hit ? tb_q[s] : '0;
    ex = hit ? exp_q[s] : EPOCH_NONE;
    od = hit ? old_q[s] : '0;
    nw = hit ? new_q[s] : '0;
    lk = lk + {{32{q_item_i.live_key_delta[31]}}, q_item_i.live_key_delta};
    tk = tk + {{32{q_item_i.total_key_delta[31]}}, q_item_i.total_key_delta};
    lb = lb + {{32{q_item_i.live_byte_delta[31]}}, q_item_i.live_byte_delta};
    tb = tb + {{32{q_item_i.total_byte_delta[31]}}, q_item_i.total_byte_delta};
    if (q_item_i.expiry_epoch < ex) ex = q_item_i.expiry_epoch;
    if ((q_item_i.tstamp != '0 && q_item_i.tstamp < od) || od == '0) od = q_item_i.tstamp;
    if ((q_item_i.tstamp != '0 && q_item_i.tstamp > nw) || nw == '0) nw = q_item_i.tstamp;
    res_d = '0;
    if (hit || (q_item_i.create_if_absent && fre)) begin
      res_d.status          = hit ? ST_UPDATED : ST_CREATED;
      res_d.slot            = 4'(s);
      res_d.lkey_cnt        = lk;
      res_d.tkey_cnt        = tk;
      res_d.lbyte_cnt       = lb;
      res_d.tbyte_cnt       = tb;
      res_d.earliest_expiry = ex;
      res_d.oldest_stamp    = od;
      res_d.newest_stamp    = nw;
    end else begin
      res_d.status = q_item_i.create_if_absent ? ST_FULL : ST_SKIPPED;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (q_ready_o) out_valid_q <= q_valid_i;
      if (wr) vld_q[s] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) res_q <= res_d;
    if (wr) begin
      id_q[s]  <= q_item_i.file_id;
      lk_q[s]  <= lk;
      tk_q[s]  <= tk;
      lb_q[s]  <= lb;
      tb_q[s]  <= tb;
      exp_q[s] <= ex;
      old_q[s] <= od;
      new_q[s] <= nw;
    end
  end
endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import fsat_pkg::*;

  localparam int unsigned ENTRIES = 16;
  localparam int unsigned RANDOM_ITEMS = 1100;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  // file_id, tstamp, expiry_epoch, live_key_delta, total_key_delta,
  // live_byte_delta, total_byte_delta
  logic [255:0] s_axis_tdata;
  // create_if_absent
  logic         s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  // status, slot, live key count, total key count, live byte count,
  // total byte count, earliest_expiry, oldest_stamp, newest_stamp, zero pad
  logic [391:0] m_axis_tdata;

  file_stats_accumulator_table_core #(.TABLE_ENTRIES(ENTRIES)) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // shadow copy of the statistics table
  logic        shadow_valid [ENTRIES];
  logic [31:0] shadow_id [ENTRIES];
  logic [63:0] shadow_lkeys [ENTRIES];
  logic [63:0] shadow_tkeys [ENTRIES];
  logic [63:0] shadow_lbytes [ENTRIES];
  logic [63:0] shadow_tbytes [ENTRIES];
  logic [63:0] shadow_expiry [ENTRIES];
  logic [31:0] shadow_oldest [ENTRIES];
  logic [31:0] shadow_newest [ENTRIES];

  result_t pending_stats [$];
  int      mismatches;
  bit      quiet_phase;
  bit      stim_done;

  // directed rows: item, whether a typed-in result applies, that result
  typedef struct {
    item_t   item;
    bit      fixed;
    result_t res;
  } stim_row_t;

  stim_row_t rows [$];
  // typed-in expectations in send order, one per item sent
  stim_row_t typed_q [$];

  always #2ns clk_i = ~clk_i;

  // table update and expected statistics for one accepted item
  function automatic result_t update_stats(item_t it);
    result_t r;
    int hit;
    int free_idx;
    int s;
    hit = -1;
    free_idx = -1;
    r = '0;
    for (int k = 0; k < ENTRIES; k++) begin
      if (shadow_valid[k]) begin
        if (hit < 0 && shadow_id[k] == it.file_id) hit = k;
      end else if (free_idx < 0) begin
        free_idx = k;
      end
    end
    if (hit >= 0) begin
      s = hit;
      r.status = ST_UPDATED;
    end else if (!it.create_if_absent) begin
      r.status = ST_SKIPPED;
      return r;
    end else if (free_idx < 0) begin
      r.status = ST_FULL;
      return r;
    end else begin
      s = free_idx;
      r.status = ST_CREATED;
      shadow_valid[s] = 1'b1;
      shadow_id[s] = it.file_id;
      shadow_lkeys[s] = '0;
      shadow_tkeys[s] = '0;
      shadow_lbytes[s] = '0;
      shadow_tbytes[s] = '0;
      shadow_expiry[s] = EPOCH_NONE;
      shadow_oldest[s] = '0;
      shadow_newest[s] = '0;
    end
    shadow_lkeys[s] += {{32{it.live_key_delta[31]}}, it.live_key_delta};
    shadow_tkeys[s] += {{32{it.total_key_delta[31]}}, it.total_key_delta};
    shadow_lbytes[s] += {{32{it.live_byte_delta[31]}}, it.live_byte_delta};
    shadow_tbytes[s] += {{32{it.total_byte_delta[31]}}, it.total_byte_delta};
    if (it.expiry_epoch < shadow_expiry[s]) shadow_expiry[s] = it.expiry_epoch;
    if ((it.tstamp != 0 && it.tstamp < shadow_oldest[s]) || shadow_oldest[s] == 0)
      shadow_oldest[s] = it.tstamp;
    if ((it.tstamp != 0 && it.tstamp > shadow_newest[s]) || shadow_newest[s] == 0)
      shadow_newest[s] = it.tstamp;
    r.slot = s[3:0];
    r.lkey_cnt = shadow_lkeys[s];
    r.tkey_cnt = shadow_tkeys[s];
    r.lbyte_cnt = shadow_lbytes[s];
    r.tbyte_cnt = shadow_tbytes[s];
    r.earliest_expiry = shadow_expiry[s];
    r.oldest_stamp = shadow_oldest[s];
    r.newest_stamp = shadow_newest[s];
    return r;
  endfunction

  function automatic item_t make_item(logic [31:0] id, logic [31:0] ts, logic [63:0] ex,
                                      logic [31:0] d0, logic [31:0] d1, logic [31:0] d2,
                                      logic [31:0] d3, logic cr);
    item_t it;
    it.file_id = id;
    it.tstamp = ts;
    it.expiry_epoch = ex;
    it.live_key_delta = d0;
    it.total_key_delta = d1;
    it.live_byte_delta = d2;
    it.total_byte_delta = d3;
    it.create_if_absent = cr;
    return it;
  endfunction

  function automatic void add_row(item_t it, bit fixed, result_t res);
    stim_row_t r;
    r.item = it;
    r.fixed = fixed;
    r.res = res;
    rows.push_back(r);
  endfunction

  function automatic logic [31:0] rand_delta();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 15);
      1: return -$urandom_range(1, 15);
      2: return {$urandom_range(0, 1) ? 2'b10 : 2'b01, 30'($urandom())};
      default: return $urandom();
    endcase
  endfunction

  // ids drawn from a small pool around the directed ids so that hits, full and
  // skip reports all occur
  function automatic item_t rand_item(int pool);
    logic [31:0] ts;
    logic [63:0] ex;
    case ($urandom_range(0, 3))
      0: ts = '0;
      1: ts = '1;
      default: ts = $urandom();
    endcase
    case ($urandom_range(0, 3))
      0: ex = EPOCH_NONE;
      1: ex = 64'($urandom_range(0, 3));
      default: ex = {$urandom(), $urandom()};
    endcase
    return make_item(32'h0000_0100 ^ 32'($urandom_range(0, pool - 1)) ^
                     ($urandom_range(0, 7) == 0 ? $urandom() : 32'h0),
                     ts, ex, rand_delta(), rand_delta(), rand_delta(), rand_delta(),
                     $urandom_range(0, 9) < 7);
  endfunction

  // sender: queues the typed-in expectation and drives one item, with random idle gaps
  task automatic send_item(item_t it, bit fixed, result_t res);
    stim_row_t tr;
    tr.item = it;
    tr.fixed = fixed;
    tr.res = res;
    typed_q.push_back(tr);
    while (!quiet_phase && $urandom_range(0, 99) < 38) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= it[255:0];
    s_axis_tuser <= it.create_if_absent;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // expectations are queued on acceptance
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      item_t it;
      it = {s_axis_tuser, s_axis_tdata};
      pending_stats.push_back(update_stats(it));
    end
  end

  // result checker and receiver stalls
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      result_t   got;
      result_t   want;
      stim_row_t tr;
      got = m_axis_tdata[389:0];
      if (pending_stats.size() == 0 || typed_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer: %h", got);
      end else begin
        want = pending_stats.pop_front();
        tr = typed_q.pop_front();
        if (tr.fixed && got !== tr.res) begin
          mismatches++;
          if (mismatches <= 10)
            $display("directed result: expected %h actual %h", tr.res, got);
        end else if (got.status !== want.status || got.slot !== want.slot ||
            got.lkey_cnt !== want.lkey_cnt || got.tkey_cnt !== want.tkey_cnt ||
            got.lbyte_cnt !== want.lbyte_cnt || got.tbyte_cnt !== want.tbyte_cnt ||
            got.earliest_expiry !== want.earliest_expiry ||
            got.oldest_stamp !== want.oldest_stamp ||
            got.newest_stamp !== want.newest_stamp) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected %s slot %0d lk %h tk %h lb %h tb %h ex %h old %h new %h",
                     want.status.name(), want.slot, want.lkey_cnt, want.tkey_cnt,
                     want.lbyte_cnt, want.tbyte_cnt, want.earliest_expiry,
                     want.oldest_stamp, want.newest_stamp);
            $display("          actual   %s slot %0d lk %h tk %h lb %h tb %h ex %h old %h new %h",
                     got.status.name(), got.slot, got.lkey_cnt, got.tkey_cnt,
                     got.lbyte_cnt, got.tbyte_cnt, got.earliest_expiry,
                     got.oldest_stamp, got.newest_stamp);
          end
        end
      end
    end
    if (rst_ni) m_axis_tready <= quiet_phase || stim_done || $urandom_range(0, 99) >= 38;
  end

  initial begin
    #2ms;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    result_t zero_res;
    result_t skip_res;
    result_t full_res;
    result_t first_res;
    int wait_cycles;
    clk_i = 1'b0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    m_axis_tready = 1'b0;
    mismatches = 0;
    quiet_phase = 1'b0;
    stim_done = 1'b0;
    for (int k = 0; k < ENTRIES; k++) shadow_valid[k] = 1'b0;

    zero_res = '0;
    skip_res = '0;
    skip_res.status = ST_SKIPPED;
    full_res = '0;
    full_res.status = ST_FULL;
    // fresh entry with all-ones deltas and stamps
    first_res = '0;
    first_res.status = ST_CREATED;
    first_res.lkey_cnt = '1;
    first_res.tkey_cnt = '1;
    first_res.lbyte_cnt = '1;
    first_res.tbyte_cnt = '1;
    first_res.earliest_expiry = EPOCH_NONE;
    first_res.oldest_stamp = '1;
    first_res.newest_stamp = '1;

    // absent without create on an empty table
    add_row(make_item('1, '1, '1, '1, '1, '1, '1, 1'b0), 1, skip_res);
    // create with extreme fields
    add_row(make_item('1, '1, EPOCH_NONE, '1, '1, '1, '1, 1'b1), 1, first_res);
    // hit: most positive deltas, zero expiry, zero stamp keeps stamps
    add_row(make_item('1, '0, '0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                      32'h7FFF_FFFF, 1'b0), 0, zero_res);
    // most negative deltas
    add_row(make_item('1, 32'd1, 64'd5, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                      32'h8000_0000, 1'b1), 0, zero_res);
    // create with zero stamp, then a set stamp fills the unset ones
    add_row(make_item('0, '0, 64'd100, '0, '0, '0, '0, 1'b1), 0, zero_res);
    add_row(make_item('0, 32'd50, 64'd200, 32'd1, 32'd2, 32'd3, 32'd4, 1'b0), 0, zero_res);
    add_row(make_item('0, 32'd20, 64'd50, 32'd1, 32'd2, 32'd3, 32'd4, 1'b0), 0, zero_res);
    add_row(make_item('0, 32'd90, EPOCH_NONE, 32'd1, 32'd2, 32'd3, 32'd4, 1'b0), 0, zero_res);
    // fill the table, then overflow it
    for (int k = 2; k < ENTRIES; k++)
      add_row(make_item(32'h100 + k, 32'(k), 64'(k), 32'(k), 32'(-k), 32'(k), 32'(-k), 1'b1),
              0, zero_res);
    add_row(make_item(32'hDEAD_BEEF, 32'd7, 64'd7, 32'd7, 32'd7, 32'd7, 32'd7, 1'b1), 1,
            full_res);
    add_row(make_item(32'hDEAD_BEEF, 32'd7, 64'd7, 32'd7, 32'd7, 32'd7, 32'd7, 1'b0), 1,
            skip_res);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part; typed-in results are checked against the block directly
    foreach (rows[i]) begin
      send_item(rows[i].item, rows[i].fixed, rows[i].res);
    end
    s_axis_tvalid <= 1'b0;

    // hold off until every result has come back
    while (pending_stats.size() != 0) @(posedge clk_i);

    // the table stays full, so repeated ids give hits and others full/skip reports
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      quiet_phase = (n >= 400 && n < 550);
      send_item(rand_item(n < 700 ? 24 : 6), 1'b0, zero_res);
      if (n == 800) begin
        s_axis_tvalid <= 1'b0;
        while (pending_stats.size() != 0) @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b0;
    stim_done = 1'b1;

    wait_cycles = 0;
    while (pending_stats.size() != 0 && wait_cycles < 10000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && pending_stats.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
